@@ rtl/bsq_pkg.sv @@
// ----------------------------------------------------------------------------
// bsq_pkg
// Shared types and codes for the buzzer service queue.
// ----------------------------------------------------------------------------
package bsq_pkg;

  localparam int NUM_BUZZERS = 256;
  localparam int ID_W        = 8;
  localparam int CNT_W       = 9;
  localparam int SLOTS       = 4;

  localparam logic [1:0] OP_GIVE  = 2'd0;
  localparam logic [1:0] OP_SEAT  = 2'd1;
  localparam logic [1:0] OP_KICK  = 2'd2;
  localparam logic [1:0] OP_BRIBE = 2'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_EMPTY  = 3'd1;
  localparam logic [2:0] ST_RANGE  = 3'd2;
  localparam logic [2:0] ST_ABSENT = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;

  // One entry of the link memory.
  typedef struct packed {
    logic [ID_W-1:0] prev;
    logic [ID_W-1:0] next;
  } link_t;

  // One pending link write, with separate enables for the two halves.
  typedef struct packed {
    logic            wr_prev;
    logic            wr_next;
    logic [ID_W-1:0] addr;
    link_t           data;
  } wr_slot_t;

endpackage

@@ rtl/bsq_link_ram.sv @@
// ----------------------------------------------------------------------------
// bsq_link_ram
// Link memory with one read port (registered data) and one write port with
// separate enables for the prev and next halves.
// ----------------------------------------------------------------------------
module bsq_link_ram (
  input  logic                     clk,
  input  logic [bsq_pkg::ID_W-1:0] rd_addr,
  output bsq_pkg::link_t           rd_data,
  input  bsq_pkg::wr_slot_t        wr
);

  bsq_pkg::link_t mem [bsq_pkg::NUM_BUZZERS];

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr.wr_prev) begin
      mem[wr.addr].prev <= wr.data.prev;
    end
    if (wr.wr_next) begin
      mem[wr.addr].next <= wr.data.next;
    end
  end

endmodule

@@ rtl/buzzer_service_queue.sv @@
// ----------------------------------------------------------------------------
// buzzer_service_queue
// Waiting line of buzzer IDs kept as a doubly linked list in a link memory,
// with a stack memory of returned IDs for reuse.
// ----------------------------------------------------------------------------
//  Channel  Ports        Fields (lowest bit up)
//  in       in_tdata     op[1:0], buzzer_id[9:2]
//  out      out_tdata    result_id[7:0], status[10:8], line_length[19:11]
//
// An accepted command steps through one memory read (S_IDLE), one update
// (S_EXEC), the link writes held in the slots, issued in turn through the single
// write port (S_WRITE), and the hand-off of the result (S_DONE). Refused commands go from S_IDLE straight to S_DONE.
// Reset clears the control state and the membership flags; memories are not cleared. A stalled output
// holds the finished word while the next command is already accepted.
module buzzer_service_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // op[1:0], buzzer_id[9:2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // result_id[7:0], status[10:8], line_length[19:11]
);

  localparam int ID_W  = bsq_pkg::ID_W;
  localparam int CNT_W = bsq_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_WRITE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [ID_W-1:0]     head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]    rc_r, rc_nxt, ic_r, ic_nxt, wc_r, wc_nxt;
  logic [bsq_pkg::NUM_BUZZERS-1:0] flag_r, flag_nxt;
  logic [ID_W-1:0]     res_r, res_nxt;
  logic [2:0]          stat_r, stat_nxt;
  logic [1:0]          wcnt_r, wcnt_nxt;
  bsq_pkg::wr_slot_t   slot_r [bsq_pkg::SLOTS];
  bsq_pkg::wr_slot_t   slot_nxt [bsq_pkg::SLOTS];
  logic                out_valid_r, out_valid_nxt;
  logic [23:0]         out_data_r, out_data_nxt;

  logic [1:0]          in_op;
  logic [ID_W-1:0]     in_id;
  logic                accept;
  logic [ID_W-1:0]     link_raddr;
  bsq_pkg::link_t      link_rdata;
  bsq_pkg::wr_slot_t   link_wr;
  logic [ID_W-1:0]     stk_mem [bsq_pkg::NUM_BUZZERS];
  logic [ID_W-1:0]     stk_rdata;
  logic                stk_we;
  logic [ID_W-1:0]     stk_waddr, stk_wdata;
  logic [CNT_W-1:0]    wc_dec;
  bsq_pkg::wr_slot_t   empty_slot;

  function automatic logic [ID_W-1:0] rc_dec_addr(input logic [CNT_W-1:0] rc);
    logic [CNT_W-1:0] t;
    t = rc - CNT_W'(1);
    return t[ID_W-1:0];
  endfunction

  assign in_op  = in_tdata[1:0];
  assign in_id  = in_tdata[9:2];
  assign in_tready = (state_r == S_IDLE);
  assign accept = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign empty_slot = '0;
  assign wc_dec = wc_r - CNT_W'(1);

  assign link_raddr = (in_op == bsq_pkg::OP_SEAT) ? head_r : in_id;
  assign link_wr = (state_r == S_WRITE) ? slot_r[wcnt_r] : empty_slot;

  bsq_link_ram u_link (
    .clk     (clk),
    .rd_addr (link_raddr),
    .rd_data (link_rdata),
    .wr      (link_wr)
  );

  // Returned-ID stack memory.
  always_ff @(posedge clk) begin
    stk_rdata <= stk_mem[rc_dec_addr(rc_r)];
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    id_nxt = id_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    rc_nxt = rc_r;
    ic_nxt = ic_r;
    wc_nxt = wc_r;
    flag_nxt = flag_r;
    res_nxt = res_r;
    stat_nxt = stat_r;
    wcnt_nxt = wcnt_r;
    for (int k = 0; k < bsq_pkg::SLOTS; k++) slot_nxt[k] = slot_r[k];
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r;
    stk_we = 1'b0;
    stk_waddr = rc_r[ID_W-1:0];
    stk_wdata = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt = in_op;
          id_nxt = in_id;
          res_nxt = '0;
          stat_nxt = bsq_pkg::ST_OK;
          for (int k = 0; k < bsq_pkg::SLOTS; k++) slot_nxt[k] = '0;
          state_nxt = S_EXEC;
          case (in_op)
            bsq_pkg::OP_GIVE: begin
              if (rc_r == '0 && ic_r == CNT_W'(bsq_pkg::NUM_BUZZERS)) begin
                stat_nxt = bsq_pkg::ST_FULL;
              end
            end
            bsq_pkg::OP_SEAT: begin
              if (wc_r == '0) stat_nxt = bsq_pkg::ST_EMPTY;
            end
            default: begin
              if ({1'b0, in_id} >= ic_r) stat_nxt = bsq_pkg::ST_RANGE;
              else if (wc_r == '0) stat_nxt = bsq_pkg::ST_EMPTY;
              else if (!flag_r[in_id]) stat_nxt = bsq_pkg::ST_ABSENT;
              else if (in_op == bsq_pkg::OP_BRIBE && in_id == head_r) begin
                stat_nxt = bsq_pkg::ST_ABSENT;
              end
            end
          endcase
          if (stat_nxt != bsq_pkg::ST_OK) state_nxt = S_DONE;
        end
      end

      S_EXEC: begin
        wcnt_nxt = '0;
        state_nxt = S_WRITE;
        case (op_r)
          bsq_pkg::OP_GIVE: begin
            logic [ID_W-1:0] g;
            g = (rc_r != '0) ? stk_rdata : ic_r[ID_W-1:0];
            if (rc_r != '0) rc_nxt = rc_r - CNT_W'(1);
            else ic_nxt = ic_r + CNT_W'(1);
            slot_nxt[0] = '{wr_prev: 1'b1, wr_next: 1'b1, addr: g,
                            data: '{prev: (wc_r != '0) ? tail_r : '0, next: '0}};
            if (wc_r != '0) begin
              slot_nxt[1] = '{wr_prev: 1'b0, wr_next: 1'b1, addr: tail_r,
                              data: '{prev: '0, next: g}};
            end else begin
              head_nxt = g;
            end
            tail_nxt = g;
            flag_nxt[g] = 1'b1;
            wc_nxt = wc_r + CNT_W'(1);
            res_nxt = g;
          end
          default: begin
            logic [ID_W-1:0] u, p, n;
            u = (op_r == bsq_pkg::OP_SEAT) ? head_r : id_r;
            p = link_rdata.prev;
            n = link_rdata.next;
            // Unlink u from wherever it sits in the line.
            if (u == head_r) begin
              head_nxt = n;
            end else begin
              slot_nxt[0] = '{wr_prev: 1'b0, wr_next: 1'b1, addr: p,
                              data: '{prev: '0, next: n}};
            end
            if (u == tail_r) begin
              tail_nxt = p;
            end else begin
              slot_nxt[1] = '{wr_prev: 1'b1, wr_next: 1'b0, addr: n,
                              data: '{prev: p, next: '0}};
            end
            if (op_r == bsq_pkg::OP_BRIBE) begin
              // Relink at the front; the old head stays the second entry.
              slot_nxt[2] = '{wr_prev: 1'b1, wr_next: 1'b1, addr: u,
                              data: '{prev: '0, next: head_r}};
              slot_nxt[3] = '{wr_prev: 1'b1, wr_next: 1'b0, addr: head_r,
                              data: '{prev: u, next: '0}};
              head_nxt = u;
            end else begin
              flag_nxt[u] = 1'b0;
              wc_nxt = wc_dec;
              if (wc_dec == '0) begin
                head_nxt = '0;
                tail_nxt = '0;
              end
              if (rc_r < CNT_W'(bsq_pkg::NUM_BUZZERS)) begin
                stk_we = 1'b1;
                stk_wdata = u;
                rc_nxt = rc_r + CNT_W'(1);
              end
              if (op_r == bsq_pkg::OP_SEAT) res_nxt = u;
            end
          end
        endcase
      end

      S_WRITE: begin
        wcnt_nxt = wcnt_r + 2'd1;
        if (wcnt_r == 2'(bsq_pkg::SLOTS - 1)) state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = {4'b0, wc_r, stat_r, res_r};
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= '0;
      tail_r <= '0;
      rc_r <= '0;
      ic_r <= '0;
      wc_r <= '0;
      flag_r <= '0;
      wcnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      rc_r <= rc_nxt;
      ic_r <= ic_nxt;
      wc_r <= wc_nxt;
      flag_r <= flag_nxt;
      wcnt_r <= wcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    id_r <= id_nxt;
    res_r <= res_nxt;
    stat_r <= stat_nxt;
    out_data_r <= out_data_nxt;
    for (int k = 0; k < bsq_pkg::SLOTS; k++) slot_r[k] <= slot_nxt[k];
  end

  // The flag vector and the waiting count must agree between commands.
  a_flag_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> $countones(flag_r) == wc_r)
    else $error("membership flags disagree with line length");

  // Waiting and returned IDs never exceed the issued ones.
  a_id_budget: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> (10'(rc_r) + 10'(wc_r)) <= 10'(ic_r))
    else $error("more IDs in use than issued");

  // An empty line has both ends at zero.
  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE && wc_r == '0 |-> head_r == '0 && tail_r == '0)
    else $error("empty line with stale ends");

endmodule

@@ verif/buzzer_service_queue_tb.sv @@
// ----------------------------------------------------------------------------
// buzzer_service_queue_tb
// Drives give, seat, kick-out and bribe commands into the buzzer service queue
// and checks every result word against a behavioral line and ID-reuse model.
// ----------------------------------------------------------------------------
module buzzer_service_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Packed from the top bit down, so the last field sits lowest.
  typedef struct packed {
    logic [bsq_pkg::ID_W-1:0] id;
    logic [1:0]               op;
  } cmd_t;

  typedef struct packed {
    logic [bsq_pkg::CNT_W-1:0] line_length;
    logic [2:0]                status;
    logic [bsq_pkg::ID_W-1:0]  result_id;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  buzzer_service_queue DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: the line as a doubly linked list plus the reuse stack.
  logic [bsq_pkg::ID_W-1:0]  nxt [bsq_pkg::NUM_BUZZERS];
  logic [bsq_pkg::ID_W-1:0]  prv [bsq_pkg::NUM_BUZZERS];
  bit                        waiting [bsq_pkg::NUM_BUZZERS];
  logic [bsq_pkg::ID_W-1:0]  reuse_stack [bsq_pkg::NUM_BUZZERS];
  logic [bsq_pkg::ID_W-1:0]  head_q, tail_q;
  int                        reuse_cnt, issued_cnt, line_cnt;

  cmd_t   pending_cmds [$];
  reply_t expected_replies [$];
  int     errors = 0;
  int     accepted = 0;
  int     checked = 0;
  int     status_seen [5];
  int     send_idle = 15;
  int     recv_idle = 51;
  bit     hold_off = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d (reply %0d)", what, got, want, checked);
    errors++;
  endtask

  function automatic void line_remove(input logic [bsq_pkg::ID_W-1:0] id);
    logic [bsq_pkg::ID_W-1:0] p, n;
    p = prv[id];
    n = nxt[id];
    if (id == head_q) head_q = n;
    else nxt[p] = n;
    if (id == tail_q) tail_q = p;
    else prv[n] = p;
    waiting[id] = 1'b0;
    if (line_cnt > 0) line_cnt--;
    if (line_cnt == 0) begin
      head_q = '0;
      tail_q = '0;
    end
  endfunction

  function automatic void give_back(input logic [bsq_pkg::ID_W-1:0] id);
    if (reuse_cnt < bsq_pkg::NUM_BUZZERS) begin
      reuse_stack[reuse_cnt] = id;
      reuse_cnt++;
    end
  endfunction

  function automatic reply_t predict_service(input cmd_t c);
    reply_t r;
    r = '0;
    r.status = bsq_pkg::ST_OK;
    case (c.op)
      bsq_pkg::OP_GIVE: begin
        if (reuse_cnt == 0 && issued_cnt >= bsq_pkg::NUM_BUZZERS) begin
          r.status = bsq_pkg::ST_FULL;
        end else begin
          if (reuse_cnt > 0) begin
            reuse_cnt--;
            r.result_id = reuse_stack[reuse_cnt];
          end else begin
            r.result_id = issued_cnt[bsq_pkg::ID_W-1:0];
            issued_cnt++;
          end
          nxt[r.result_id] = '0;
          if (line_cnt == 0) begin
            prv[r.result_id] = '0;
            head_q = r.result_id;
          end else begin
            prv[r.result_id] = tail_q;
            nxt[tail_q] = r.result_id;
          end
          tail_q = r.result_id;
          waiting[r.result_id] = 1'b1;
          line_cnt++;
        end
      end
      bsq_pkg::OP_SEAT: begin
        if (line_cnt == 0) begin
          r.status = bsq_pkg::ST_EMPTY;
        end else begin
          r.result_id = head_q;
          line_remove(head_q);
          give_back(r.result_id);
        end
      end
      default: begin
        if (int'(c.id) >= issued_cnt) r.status = bsq_pkg::ST_RANGE;
        else if (line_cnt == 0) r.status = bsq_pkg::ST_EMPTY;
        else if (!waiting[c.id]) r.status = bsq_pkg::ST_ABSENT;
        else if (c.op == bsq_pkg::OP_KICK) begin
          line_remove(c.id);
          give_back(c.id);
        end else if (c.id == head_q) begin
          r.status = bsq_pkg::ST_ABSENT;
        end else begin
          line_remove(c.id);
          prv[c.id] = '0;
          if (line_cnt == 0) begin
            nxt[c.id] = '0;
            tail_q = c.id;
          end else begin
            nxt[c.id] = head_q;
            prv[head_q] = c.id;
          end
          head_q = c.id;
          waiting[c.id] = 1'b1;
          line_cnt++;
        end
      end
    endcase
    r.line_length = line_cnt[bsq_pkg::CNT_W-1:0];
    return r;
  endfunction

  // Driver: keeps valid high while a word waits, advancing on acceptance.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_replies.push_back(predict_service(cmd_t'(in_tdata[9:0])));
        accepted++;
      end
      if ((!in_tvalid || in_tready) ) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {6'b0, pending_cmds.pop_front()};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, and compare each accepted reply.
  always @(posedge clk) begin
    reply_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = reply_t'(out_tdata[19:0]);
        if (expected_replies.size() == 0) begin
          report_mismatch("unexpected reply word", int'(out_tdata), 0);
        end else begin
          want = expected_replies.pop_front();
          if (got.result_id !== want.result_id)
            report_mismatch("result_id", got.result_id, want.result_id);
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
          if (got.line_length !== want.line_length)
            report_mismatch("line_length", got.line_length, want.line_length);
          if (want.status <= bsq_pkg::ST_FULL) status_seen[want.status]++;
        end
        checked++;
      end
      out_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end
  end

  // Long receiver stall so the block backs up and stops taking commands.
  initial begin
    int n;
    @(posedge rst_n);
    repeat (300) @(posedge clk);
    hold_off = 1'b1;
    for (n = 0; n < 400; n++) @(posedge clk);
    hold_off = 1'b0;
  end

  function automatic cmd_t mk(input logic [1:0] op, input logic [bsq_pkg::ID_W-1:0] id);
    cmd_t c;
    c.op = op;
    c.id = id;
    return c;
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_tvalid || expected_replies.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Random traffic; op weights bias the line toward a given fill level.
  task automatic add_random(input int count, input int give_pct);
    int i, p;
    logic [1:0] op;
    for (i = 0; i < count; i++) begin
      p = $urandom_range(99);
      if (p < give_pct) op = bsq_pkg::OP_GIVE;
      else op = 2'($urandom_range(3, 1));
      // Mostly IDs from 0 to 40, sometimes any value.
      pending_cmds.push_back(mk(op, ($urandom_range(9) == 0) ? 8'($urandom) :
                                    8'($urandom_range(40))));
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < bsq_pkg::NUM_BUZZERS; i++) begin
      waiting[i] = 1'b0;
      nxt[i] = '0;
      prv[i] = '0;
      reuse_stack[i] = '0;
    end
    head_q = '0;
    tail_q = '0;
    reuse_cnt = 0;
    issued_cnt = 0;
    line_cnt = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: empty-line refusals, out-of-range IDs, bribe of head, reuse.
    pending_cmds.push_back(mk(bsq_pkg::OP_SEAT, 8'd0));
    pending_cmds.push_back(mk(bsq_pkg::OP_KICK, 8'd0));
    pending_cmds.push_back(mk(bsq_pkg::OP_BRIBE, 8'd255));
    for (i = 0; i < 4; i++) pending_cmds.push_back(mk(bsq_pkg::OP_GIVE, 8'd0));
    pending_cmds.push_back(mk(bsq_pkg::OP_BRIBE, 8'd0));
    pending_cmds.push_back(mk(bsq_pkg::OP_BRIBE, 8'd3));
    pending_cmds.push_back(mk(bsq_pkg::OP_BRIBE, 8'd2));
    pending_cmds.push_back(mk(bsq_pkg::OP_KICK, 8'd1));
    pending_cmds.push_back(mk(bsq_pkg::OP_KICK, 8'd1));
    pending_cmds.push_back(mk(bsq_pkg::OP_KICK, 8'd4));
    pending_cmds.push_back(mk(bsq_pkg::OP_SEAT, 8'd0));
    pending_cmds.push_back(mk(bsq_pkg::OP_GIVE, 8'd0));
    pending_cmds.push_back(mk(bsq_pkg::OP_KICK, 8'd0));
    pending_cmds.push_back(mk(bsq_pkg::OP_SEAT, 8'd0));
    pending_cmds.push_back(mk(bsq_pkg::OP_SEAT, 8'd0));
    pending_cmds.push_back(mk(bsq_pkg::OP_SEAT, 8'd0));
    pending_cmds.push_back(mk(bsq_pkg::OP_KICK, 8'd2));
    add_random(330, 40);
    wait_drained();
    send_idle = 51;
    recv_idle = 15;
    // Fill to capacity, hit full, then churn with IDs from the whole range.
    for (i = 0; i < 260; i++) pending_cmds.push_back(mk(bsq_pkg::OP_GIVE, 8'($urandom)));
    for (i = 0; i < 90; i++)
      pending_cmds.push_back(mk(2'($urandom_range(3, 1)), 8'($urandom)));
    wait_drained();
    send_idle = 0;
    recv_idle = 0;
    add_random(350, 50);
    for (i = 0; i < 40; i++)
      pending_cmds.push_back(mk(2'($urandom_range(3)), 8'($urandom_range(255, 200))));
    wait_drained();
    $display("Ran %0d commands, checked %0d replies.", accepted, checked);
    $display("Statuses ok/empty/range/absent/full: %0d/%0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4]);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout after %0d replies", checked);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
rtl/bsq_pkg.sv
rtl/bsq_link_ram.sv
rtl/buzzer_service_queue.sv
verif/buzzer_service_queue_tb.sv
